// ===== design/map_xor_rotate_checksum_macros.svh =====
// Assertion macros for the checksum RTL.
`ifndef MAP_XOR_ROTATE_CHECKSUM_MACROS_SVH
`define MAP_XOR_ROTATE_CHECKSUM_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define MXRC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mxrc assertion failed");

// Next-cycle implication, disabled during reset.
`define MXRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mxrc assertion failed");

`else

`define MXRC_ASSERT_NOW(label, clk, rst, ante, cons)
`define MXRC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/mxrc_pkg.sv =====
// Types, constants and helper functions for the xor-rotate map checksum.
package mxrc_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ROT_AMT = 3;
  localparam logic [WORD_W-1:0] MAP_MIX_CONST = 32'h03F1_379E;

  localparam logic [1:0] ROLE_FIRST_SCRIPT  = 2'd0;
  localparam logic [1:0] ROLE_SECOND_SCRIPT = 2'd1;
  localparam logic [1:0] ROLE_MAP_FILE      = 2'd2;

  localparam logic [1:0] CNT_ZERO  = 2'd0;
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] CNT_THREE = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
    logic [1:0] file_role;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] file_sum;
    logic [WORD_W-1:0] map_sum;
  } result_t;

  // Held request handed from the input register to the fold stage.
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  function automatic logic [WORD_W-1:0] rotl3(input logic [WORD_W-1:0] x);
    return (x << ROT_AMT) | (x >> (WORD_W - ROT_AMT));
  endfunction

endpackage

// ===== design/mxrc_stream_if.sv =====
// Valid/ready channel interfaces for byte requests and checksum results.
interface mxrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_byte;
  logic [1:0] file_role;

  modport source(output valid, data_byte, byte_valid, last_byte, file_role, input ready);
  modport sink(input valid, data_byte, byte_valid, last_byte, file_role, output ready);
endinterface

interface mxrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] file_sum;
  logic [31:0] map_sum;

  modport source(output valid, file_sum, map_sum, input ready);
  modport sink(input valid, file_sum, map_sum, output ready);
endinterface

// ===== design/mxrc_in_stage.sv =====
// Input register: captures one byte request and holds it until the fold stage takes it.
module mxrc_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mxrc_pkg::item_t       in_item,
  input  logic                  advance,
  output mxrc_pkg::stage_t      stage
);

  logic            held;
  mxrc_pkg::item_t item;

  assign in_ready    = !held || advance;
  assign stage.valid = held;
  assign stage.item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== design/mxrc_fold.sv =====
// Fold stage: word/tail checksum, map mixing, running state and result register.
`include "map_xor_rotate_checksum_macros.svh"

module mxrc_fold (
  input  logic                  clk,
  input  logic                  rst,
  input  mxrc_pkg::stage_t      stage,
  output logic                  advance,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mxrc_pkg::result_t     out_result
);

  logic [23:0]                 pending_bytes;
  logic [1:0]                  pending_count;
  logic [mxrc_pkg::WORD_W-1:0] running_sum;
  logic [mxrc_pkg::WORD_W-1:0] combined_value;

  logic [23:0]                 pending_bytes_next;
  logic [1:0]                  pending_count_next;
  logic [mxrc_pkg::WORD_W-1:0] running_sum_next;
  logic [mxrc_pkg::WORD_W-1:0] file_sum_next;
  logic [mxrc_pkg::WORD_W-1:0] combined_value_next;
  logic                        is_last;

  assign is_last = stage.item.last_byte;
  assign advance = stage.valid && (!is_last || !out_valid || out_ready);

  // Byte insertion and full-word fold.
  always_comb begin
    pending_bytes_next = pending_bytes;
    pending_count_next = pending_count;
    running_sum_next   = running_sum;
    if (stage.item.byte_valid) begin
      case (pending_count)
        mxrc_pkg::CNT_ZERO: begin
          pending_bytes_next[7:0] = stage.item.data_byte;
          pending_count_next      = mxrc_pkg::CNT_ONE;
        end
        mxrc_pkg::CNT_ONE: begin
          pending_bytes_next[15:8] = stage.item.data_byte;
          pending_count_next       = mxrc_pkg::CNT_TWO;
        end
        mxrc_pkg::CNT_TWO: begin
          pending_bytes_next[23:16] = stage.item.data_byte;
          pending_count_next        = mxrc_pkg::CNT_THREE;
        end
        default: begin
          running_sum_next   = mxrc_pkg::rotl3(running_sum ^
                                 {stage.item.data_byte, pending_bytes});
          pending_bytes_next = '0;
          pending_count_next = mxrc_pkg::CNT_ZERO;
        end
      endcase
    end
  end

  // Tail bytes, one at a time.
  always_comb begin
    file_sum_next = running_sum_next;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < pending_count_next) begin
        file_sum_next = mxrc_pkg::rotl3(file_sum_next ^
                          {24'd0, pending_bytes_next[8*k +: 8]});
      end
    end
  end

  // Map value update by file role; role three folds like a map file.
  always_comb begin
    case (stage.item.file_role)
      mxrc_pkg::ROLE_FIRST_SCRIPT: combined_value_next = file_sum_next;
      mxrc_pkg::ROLE_SECOND_SCRIPT: combined_value_next = mxrc_pkg::rotl3(
        mxrc_pkg::rotl3(combined_value ^ file_sum_next) ^ mxrc_pkg::MAP_MIX_CONST);
      default: combined_value_next = mxrc_pkg::rotl3(combined_value ^ file_sum_next);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bytes  <= '0;
      pending_count  <= mxrc_pkg::CNT_ZERO;
      running_sum    <= '0;
      combined_value <= '0;
    end else if (advance) begin
      if (is_last) begin
        pending_bytes  <= '0;
        pending_count  <= mxrc_pkg::CNT_ZERO;
        running_sum    <= '0;
        combined_value <= combined_value_next;
      end else begin
        pending_bytes <= pending_bytes_next;
        pending_count <= pending_count_next;
        running_sum   <= running_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_last) begin
      out_result.file_sum <= file_sum_next;
      out_result.map_sum  <= combined_value_next;
    end
  end

  `MXRC_ASSERT_NEXT(a_word_clears_count, clk, rst,
    advance && !is_last && stage.item.byte_valid && pending_count == mxrc_pkg::CNT_THREE,
    pending_count == mxrc_pkg::CNT_ZERO && pending_bytes == 24'd0)
  `MXRC_ASSERT_NEXT(a_end_clears_state, clk, rst,
    advance && is_last,
    out_valid && pending_count == mxrc_pkg::CNT_ZERO && running_sum == '0)
  `MXRC_ASSERT_NOW(a_result_from_last, clk, rst,
    $rose(out_valid), $past(advance && is_last))
  `MXRC_ASSERT_NOW(a_stall_only_on_full_output, clk, rst,
    stage.valid && !advance, is_last && out_valid && !out_ready)

endmodule

// ===== design/map_xor_rotate_checksum.sv =====
// Top level of the xor-rotate file checksum and map value block.
//
// Usage:
//   byte_ch carries one byte request per cycle while byte_ch.ready is high:
//   data_byte, byte_valid, last_byte, file_role. An empty file is one request with
//   byte_valid low and last_byte high; file_role is only looked at on the last
//   request of a file. sum_ch carries one result per file: file_sum and map_sum.
// Timing:
//   A request is registered at the input and then folded into the running state.
//   A last request's result is registered in the output register with sum_ch.valid.
//   Throughput is one request per cycle while no last request waits on sum_ch.
// Reset:
//   rst clears the pending bytes, running sum, map value and both valid flags.
// Stall:
//   A result waits in the output register while sum_ch.ready is low; non-last
//   requests keep flowing, and a last request waits in the input register,
//   which lowers byte_ch.ready until the output register frees up.
module map_xor_rotate_checksum (
  input logic        clk,
  input logic        rst,
  mxrc_in_if.sink    byte_ch,
  mxrc_out_if.source sum_ch
);

  mxrc_pkg::item_t   in_item;
  mxrc_pkg::stage_t  stage;
  mxrc_pkg::result_t result;
  logic              advance;

  assign in_item.data_byte  = byte_ch.data_byte;
  assign in_item.byte_valid = byte_ch.byte_valid;
  assign in_item.last_byte  = byte_ch.last_byte;
  assign in_item.file_role  = byte_ch.file_role;

  mxrc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_ch.valid),
    .in_ready (byte_ch.ready),
    .in_item  (in_item),
    .advance  (advance),
    .stage    (stage)
  );

  mxrc_fold u_fold (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .advance    (advance),
    .out_valid  (sum_ch.valid),
    .out_ready  (sum_ch.ready),
    .out_result (result)
  );

  assign sum_ch.file_sum = result.file_sum;
  assign sum_ch.map_sum  = result.map_sum;

endmodule

// ===== bench/map_xor_rotate_checksum_tb.sv =====
// Self-checking bench for the xor-rotate file checksum and map value block.
module map_xor_rotate_checksum_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ROLE_RESERVED = 2'd3;
  localparam int unsigned RAND_BYTES   = 1900;

  typedef struct {
    mxrc_pkg::item_t   req;
    bit                typed;
    mxrc_pkg::result_t sums;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  mxrc_in_if  byte_if();
  mxrc_out_if sum_if();

  map_xor_rotate_checksum u_top (
    .clk    (clk),
    .rst    (rst),
    .byte_ch(byte_if),
    .sum_ch (sum_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the checksum state.
  logic [23:0] held_bytes = '0;
  logic [1:0]  held_cnt   = mxrc_pkg::CNT_ZERO;
  logic [31:0] file_acc   = '0;
  logic [31:0] map_acc    = '0;

  mxrc_pkg::result_t expected_sums[$];
  dir_row_t          dir_rows[$];
  mxrc_pkg::result_t want;
  int                mismatches = 0;
  int                src_calm   = 0;
  int                snk_calm   = 0;

  function automatic logic [31:0] rol3(input logic [31:0] v);
    return {v[28:0], v[31:29]};
  endfunction

  function automatic bit fold_request(input mxrc_pkg::item_t req,
                                      output mxrc_pkg::result_t sums);
    logic [31:0] fsum;
    int          k;
    if (req.byte_valid) begin
      if (held_cnt == mxrc_pkg::CNT_THREE) begin
        file_acc   = rol3(file_acc ^ {req.data_byte, held_bytes});
        held_bytes = '0;
        held_cnt   = mxrc_pkg::CNT_ZERO;
      end else begin
        held_bytes[8*held_cnt +: 8] = req.data_byte;
        held_cnt = held_cnt + 2'd1;
      end
    end
    sums = '0;
    if (!req.last_byte) return 1'b0;
    fsum = file_acc;
    for (k = 0; k < held_cnt; k++) fsum = rol3(fsum ^ {24'h0, held_bytes[8*k +: 8]});
    case (req.file_role)
      mxrc_pkg::ROLE_FIRST_SCRIPT:  map_acc = fsum;
      mxrc_pkg::ROLE_SECOND_SCRIPT: map_acc = rol3(rol3(map_acc ^ fsum) ^
                                                   mxrc_pkg::MAP_MIX_CONST);
      default:                      map_acc = rol3(map_acc ^ fsum);
    endcase
    held_bytes    = '0;
    held_cnt      = mxrc_pkg::CNT_ZERO;
    file_acc      = '0;
    sums.file_sum = fsum;
    sums.map_sum  = map_acc;
    return 1'b1;
  endfunction

  // Wait before the next request or result; calm stretches give back-to-back traffic.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 60);
    return $urandom_range(0, 15);
  endfunction

  function automatic mxrc_pkg::item_t make_req(input logic [7:0] b, input logic v,
                                               input logic l, input logic [1:0] r);
    mxrc_pkg::item_t req;
    req.data_byte  = b;
    req.byte_valid = v;
    req.last_byte  = l;
    req.file_role  = r;
    return req;
  endfunction

  task automatic add_row(input logic [7:0] b, input logic v, input logic l,
                         input logic [1:0] r, input bit typed,
                         input logic [31:0] fsum, input logic [31:0] msum);
    dir_row_t row;
    row.req           = make_req(b, v, l, r);
    row.typed         = typed;
    row.sums.file_sum = fsum;
    row.sums.map_sum  = msum;
    dir_rows.push_back(row);
  endtask

  task automatic send_req(input mxrc_pkg::item_t req, input bit typed,
                          input mxrc_pkg::result_t typed_sums);
    mxrc_pkg::result_t sums;
    int                gap;
    gap = draw_wait(src_calm);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid      <= 1'b1;
    byte_if.data_byte  <= req.data_byte;
    byte_if.byte_valid <= req.byte_valid;
    byte_if.last_byte  <= req.last_byte;
    byte_if.file_role  <= req.file_role;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    if (fold_request(req, sums)) expected_sums.push_back(typed ? typed_sums : sums);
  endtask

  task automatic wait_drained();
    byte_if.valid <= 1'b0;
    do @(posedge clk); while (expected_sums.size() != 0);
  endtask

  function automatic logic [1:0] pick_role();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return mxrc_pkg::ROLE_FIRST_SCRIPT;
    if (r < 30) return mxrc_pkg::ROLE_SECOND_SCRIPT;
    if (r < 90) return mxrc_pkg::ROLE_MAP_FILE;
    return ROLE_RESERVED;
  endfunction

  initial begin
    int                sent;
    int                len;
    int                kind;
    int                i;
    logic [1:0]        role;
    mxrc_pkg::result_t none;
    none = '0;
    sent = 0;
    rst                <= 1'b1;
    byte_if.valid      <= 1'b0;
    byte_if.data_byte  <= '0;
    byte_if.byte_valid <= 1'b0;
    byte_if.last_byte  <= 1'b0;
    byte_if.file_role  <= mxrc_pkg::ROLE_FIRST_SCRIPT;

    //       byte   vld   last  role                          typed fsum          msum
    add_row(8'h00, 1'b0, 1'b1, mxrc_pkg::ROLE_FIRST_SCRIPT,  1'b1, 32'h0000_0000,
            32'h0000_0000);
    add_row(8'h00, 1'b0, 1'b1, mxrc_pkg::ROLE_SECOND_SCRIPT, 1'b1, 32'h0000_0000,
            32'h1F89_BCF0);
    add_row(8'hFF, 1'b1, 1'b1, mxrc_pkg::ROLE_FIRST_SCRIPT,  1'b1, 32'h0000_07F8,
            32'h0000_07F8);
    add_row(8'h00, 1'b1, 1'b0, mxrc_pkg::ROLE_MAP_FILE,      1'b0, '0, '0);
    add_row(8'hFF, 1'b1, 1'b0, mxrc_pkg::ROLE_SECOND_SCRIPT, 1'b0, '0, '0);
    add_row(8'h80, 1'b1, 1'b0, ROLE_RESERVED,                1'b0, '0, '0);
    add_row(8'h01, 1'b1, 1'b1, mxrc_pkg::ROLE_MAP_FILE,      1'b0, '0, '0);
    add_row(8'hAA, 1'b0, 1'b0, mxrc_pkg::ROLE_SECOND_SCRIPT, 1'b0, '0, '0);
    add_row(8'h12, 1'b1, 1'b0, mxrc_pkg::ROLE_FIRST_SCRIPT,  1'b0, '0, '0);
    add_row(8'h34, 1'b1, 1'b0, mxrc_pkg::ROLE_FIRST_SCRIPT,  1'b0, '0, '0);
    add_row(8'h56, 1'b1, 1'b0, mxrc_pkg::ROLE_FIRST_SCRIPT,  1'b0, '0, '0);
    add_row(8'h78, 1'b1, 1'b0, mxrc_pkg::ROLE_FIRST_SCRIPT,  1'b0, '0, '0);
    add_row(8'h9A, 1'b1, 1'b1, ROLE_RESERVED,                1'b0, '0, '0);
    add_row(8'h5A, 1'b1, 1'b0, mxrc_pkg::ROLE_MAP_FILE,      1'b0, '0, '0);
    add_row(8'hA5, 1'b1, 1'b0, mxrc_pkg::ROLE_MAP_FILE,      1'b0, '0, '0);
    add_row(8'h3C, 1'b0, 1'b1, mxrc_pkg::ROLE_SECOND_SCRIPT, 1'b0, '0, '0);
    add_row(8'hFF, 1'b1, 1'b0, mxrc_pkg::ROLE_MAP_FILE,      1'b0, '0, '0);
    add_row(8'hFF, 1'b1, 1'b0, mxrc_pkg::ROLE_MAP_FILE,      1'b0, '0, '0);
    add_row(8'hFF, 1'b1, 1'b1, mxrc_pkg::ROLE_MAP_FILE,      1'b0, '0, '0);
    add_row(8'hC3, 1'b1, 1'b0, mxrc_pkg::ROLE_FIRST_SCRIPT,  1'b0, '0, '0);
    add_row(8'h00, 1'b0, 1'b0, ROLE_RESERVED,                1'b0, '0, '0);
    add_row(8'h3C, 1'b1, 1'b1, mxrc_pkg::ROLE_SECOND_SCRIPT, 1'b0, '0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[n]) send_req(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].sums);
    wait_drained();

    // Random files: mostly short, a few long, some empty or cut by an invalid last request.
    while (sent < RAND_BYTES) begin
      kind = $urandom_range(0, 99);
      role = pick_role();
      if (kind < 6) begin
        send_req(make_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, role), 1'b0, none);
        sent++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_req(make_req(8'($urandom_range(0, 255)), 1'b0, 1'b0,
                              2'($urandom_range(0, 3))), 1'b0, none);
            sent++;
          end
          if (i == len - 1 && kind >= 14)
            send_req(make_req(8'($urandom_range(0, 255)), 1'b1, 1'b1, role), 1'b0, none);
          else
            send_req(make_req(8'($urandom_range(0, 255)), 1'b1, 1'b0,
                              2'($urandom_range(0, 3))), 1'b0, none);
          sent++;
        end
        if (kind < 14) begin
          send_req(make_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, role), 1'b0, none);
          sent++;
        end
      end
      if ($urandom_range(0, 29) == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_sums.size() == 0)
      $display("map_xor_rotate_checksum: match");
    else
      $display("map_xor_rotate_checksum: mismatch");
    $finish;
  end

  initial begin
    int stall;
    sum_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(snk_calm);
      if (stall > 0) begin
        sum_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      sum_if.ready <= 1'b1;
      @(posedge clk);
      while (!sum_if.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && sum_if.valid && sum_if.ready) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: result with no request pending: file_sum=%h map_sum=%h",
                 $time, sum_if.file_sum, sum_if.map_sum);
        mismatches++;
      end else begin
        want = expected_sums.pop_front();
        if (sum_if.file_sum !== want.file_sum) begin
          $display("%0t: file_sum expected %h actual %h", $time, want.file_sum,
                   sum_if.file_sum);
          mismatches++;
        end
        if (sum_if.map_sum !== want.map_sum) begin
          $display("%0t: map_sum expected %h actual %h", $time, want.map_sum,
                   sum_if.map_sum);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("map_xor_rotate_checksum: mismatch");
    $finish;
  end

endmodule
